/* hw/rtl/ges_pkg.sv */
// Shared types, command codes and saturation helpers for the gravity body stepper.
// Used by ges_ctrl, ges_dp and gravity_euler_body_step_top.
`timescale 1ns / 1ps
package ges_pkg;

  // Datapath command word
  typedef logic [4:0] cmd_t;

  localparam cmd_t CMD_NONE    = 5'd0;
  localparam cmd_t CMD_LATCH   = 5'd1;
  localparam cmd_t CMD_PLACE   = 5'd2;
  localparam cmd_t CMD_LOAD    = 5'd3;
  localparam cmd_t CMD_MUL_GM  = 5'd4;
  localparam cmd_t CMD_TAKE_P1 = 5'd5;
  localparam cmd_t CMD_READ    = 5'd6;
  localparam cmd_t CMD_DELTA   = 5'd7;
  localparam cmd_t CMD_SQ_X    = 5'd8;
  localparam cmd_t CMD_SQ_Y    = 5'd9;
  localparam cmd_t CMD_SUM     = 5'd10;
  localparam cmd_t CMD_ROOT    = 5'd11;
  localparam cmd_t CMD_KILL    = 5'd12;
  localparam cmd_t CMD_SKIP    = 5'd13;
  localparam cmd_t CMD_MUL_M   = 5'd14;
  localparam cmd_t CMD_DIV_Q   = 5'd15;
  localparam cmd_t CMD_DIV_F   = 5'd16;
  localparam cmd_t CMD_DIV_C   = 5'd17;
  localparam cmd_t CMD_DIV     = 5'd18;
  localparam cmd_t CMD_TAKE_F  = 5'd19;
  localparam cmd_t CMD_MUL_FX  = 5'd20;
  localparam cmd_t CMD_MUL_FY  = 5'd21;
  localparam cmd_t CMD_ACC_X   = 5'd22;
  localparam cmd_t CMD_ACC_Y   = 5'd23;
  localparam cmd_t CMD_UPDATE  = 5'd24;
  localparam cmd_t CMD_PUBLISH = 5'd25;

  // Item kinds carried on tuser
  localparam logic [1:0] KIND_PLACE = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_BODY_MASS   = 2'd0;
  localparam logic [1:0] REG_BODY_RADIUS = 2'd1;
  localparam logic [1:0] REG_GRAVITY     = 2'd2;

  // Datapath status toward the controller
  typedef struct packed {
    logic [1:0] kind;
    logic       dead;
    logic       idx_end;
    logic       last;
    logic       hit;
    logic       zero;
  } stat_t;

  // Take a Q16.16 product back to Q16.16, clamp to unsigned 32 bits
  function automatic logic [31:0] sat_q16(input logic [65:0] p);
    logic [31:0] r;
    r = (|p[65:48]) ? 32'hFFFF_FFFF : p[47:16];
    return r;
  endfunction

  // Clamp a wide signed value to signed 32 bits
  function automatic logic [31:0] sat_s32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/gravity_euler_body_step_top.sv */
// Place, load and other-kind items raise out_tvalid after the dispatch and done states;
// a tick runs, per attractor, 33 root steps and four 64-step divides on the
// shared divider, and stops early when a hit ends it.
// One item in work at a time; input is ready as soon as the result is loaded,
// so a transfer is taken while a result waits; a held result stalls the next one.
// Reset (synchronous, rst_n low): body at origin at rest, table empty, registers 1.0.
`timescale 1ns / 1ps
module gravity_euler_body_step_top #(
  parameter int MAX_ATTRACTORS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // coord_x, coord_y, attractor_mass, attractor_radius, thrust_x, thrust_y
  input  logic [191:0] in_tdata,
  // kind
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pos_x, pos_y, vel_x, vel_y
  output logic [127:0] out_tdata,
  // destroyed
  output logic         out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import ges_pkg::*;

  logic [31:0] body_mass_r, body_radius_r, gravity_r;
  logic        cfg_wr;
  cmd_t        cmd;
  stat_t       stat;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_mass_r   <= 32'h0001_0000;
      body_radius_r <= 32'h0001_0000;
      gravity_r     <= 32'h0001_0000;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_BODY_MASS:   body_mass_r   <= cfg_pwdata;
        REG_BODY_RADIUS: body_radius_r <= cfg_pwdata;
        REG_GRAVITY:     gravity_r     <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_BODY_MASS:   cfg_prdata = body_mass_r;
      REG_BODY_RADIUS: cfg_prdata = body_radius_r;
      REG_GRAVITY:     cfg_prdata = gravity_r;
      default:         cfg_prdata = '0;
    endcase
  end

  ges_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  ges_dp #(
    .MAX_ATTRACTORS (MAX_ATTRACTORS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .body_mass        (body_mass_r),
    .body_radius      (body_radius_r),
    .gravity_constant (gravity_r),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser)
  );

endmodule

/* hw/rtl/ges_ctrl.sv */
// Sequencer for the gravity body stepper: handshakes and per-item command stream.
// Depends on ges_pkg.
`timescale 1ns / 1ps
module ges_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  output ges_pkg::cmd_t  cmd,
  input  ges_pkg::stat_t stat
);
  import ges_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_GM    = 5'd2;
  localparam logic [4:0] S_P1    = 5'd3;
  localparam logic [4:0] S_CHK   = 5'd4;
  localparam logic [4:0] S_DELTA = 5'd5;
  localparam logic [4:0] S_SQX   = 5'd6;
  localparam logic [4:0] S_SQY   = 5'd7;
  localparam logic [4:0] S_SUM   = 5'd8;
  localparam logic [4:0] S_ROOT  = 5'd9;
  localparam logic [4:0] S_TEST  = 5'd10;
  localparam logic [4:0] S_DIVQ0 = 5'd11;
  localparam logic [4:0] S_DIVQ  = 5'd12;
  localparam logic [4:0] S_DIVF0 = 5'd13;
  localparam logic [4:0] S_DIVF  = 5'd14;
  localparam logic [4:0] S_TAKEF = 5'd15;
  localparam logic [4:0] S_MULFX = 5'd16;
  localparam logic [4:0] S_DIVX0 = 5'd17;
  localparam logic [4:0] S_DIVX  = 5'd18;
  localparam logic [4:0] S_ACCX  = 5'd19;
  localparam logic [4:0] S_MULFY = 5'd20;
  localparam logic [4:0] S_DIVY0 = 5'd21;
  localparam logic [4:0] S_DIVY  = 5'd22;
  localparam logic [4:0] S_ACCY  = 5'd23;
  localparam logic [4:0] S_UPD   = 5'd24;
  localparam logic [4:0] S_DONE  = 5'd25;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign out_tvalid = out_valid_r;
  assign in_tready  = (state_r == S_IDLE);

  // Next state and command
  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd       = CMD_LATCH;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.kind == KIND_PLACE) begin
          cmd       = CMD_PLACE;
          state_nxt = S_DONE;
        end else if (stat.kind == KIND_LOAD) begin
          cmd       = CMD_LOAD;
          state_nxt = S_DONE;
        end else if (stat.kind == KIND_TICK && !stat.dead) begin
          state_nxt = S_GM;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_GM: begin
        cmd       = CMD_MUL_GM;
        state_nxt = S_P1;
      end
      S_P1: begin
        cmd       = CMD_TAKE_P1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (stat.idx_end) begin
          state_nxt = S_UPD;
        end else begin
          cmd       = CMD_READ;
          state_nxt = S_DELTA;
        end
      end
      S_DELTA: begin
        cmd       = CMD_DELTA;
        state_nxt = S_SQX;
      end
      S_SQX: begin
        cmd       = CMD_SQ_X;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd       = CMD_SQ_Y;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd       = CMD_SUM;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        cmd = CMD_ROOT;
        if (stat.last) state_nxt = S_TEST;
      end
      S_TEST: begin
        if (stat.hit) begin
          cmd       = CMD_KILL;
          state_nxt = S_DONE;
        end else if (stat.zero) begin
          cmd       = CMD_SKIP;
          state_nxt = S_CHK;
        end else begin
          cmd       = CMD_MUL_M;
          state_nxt = S_DIVQ0;
        end
      end
      S_DIVQ0: begin
        cmd       = CMD_DIV_Q;
        state_nxt = S_DIVQ;
      end
      S_DIVQ: begin
        cmd = CMD_DIV;
        if (stat.last) state_nxt = S_DIVF0;
      end
      S_DIVF0: begin
        cmd       = CMD_DIV_F;
        state_nxt = S_DIVF;
      end
      S_DIVF: begin
        cmd = CMD_DIV;
        if (stat.last) state_nxt = S_TAKEF;
      end
      S_TAKEF: begin
        cmd       = CMD_TAKE_F;
        state_nxt = S_MULFX;
      end
      S_MULFX: begin
        cmd       = CMD_MUL_FX;
        state_nxt = S_DIVX0;
      end
      S_DIVX0: begin
        cmd       = CMD_DIV_C;
        state_nxt = S_DIVX;
      end
      S_DIVX: begin
        cmd = CMD_DIV;
        if (stat.last) state_nxt = S_ACCX;
      end
      S_ACCX: begin
        cmd       = CMD_ACC_X;
        state_nxt = S_MULFY;
      end
      S_MULFY: begin
        cmd       = CMD_MUL_FY;
        state_nxt = S_DIVY0;
      end
      S_DIVY0: begin
        cmd       = CMD_DIV_C;
        state_nxt = S_DIVY;
      end
      S_DIVY: begin
        cmd = CMD_DIV;
        if (stat.last) state_nxt = S_ACCY;
      end
      S_ACCY: begin
        cmd       = CMD_ACC_Y;
        state_nxt = S_CHK;
      end
      S_UPD: begin
        cmd       = CMD_UPDATE;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd       = CMD_PUBLISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid: set on publish, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd == CMD_PUBLISH) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hw/rtl/ges_dp.sv */
// Datapath for the gravity body stepper: body state, attractor table, shared
// multiplier, bit-serial square root and restoring divider. Depends on ges_pkg.
`timescale 1ns / 1ps
module ges_dp #(
  parameter int MAX_ATTRACTORS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  ges_pkg::cmd_t  cmd,
  output ges_pkg::stat_t stat,
  input  logic [191:0]   in_tdata,
  input  logic [1:0]     in_tuser,
  input  logic [31:0]    body_mass,
  input  logic [31:0]    body_radius,
  input  logic [31:0]    gravity_constant,
  output logic [127:0]   out_tdata,
  output logic           out_tuser
);
  import ges_pkg::*;

  localparam int CNT_W = $clog2(MAX_ATTRACTORS + 1);
  localparam int IDX_W = (MAX_ATTRACTORS > 1) ? $clog2(MAX_ATTRACTORS) : 1;
  localparam int ACC_W = 35 + CNT_W;

  // Latched item
  logic [1:0]  kind_r;
  logic [31:0] cx_r, cy_r, cm_r, cr_r, tx_r, ty_r;

  // Body state
  logic [31:0] body_x_r, body_y_r, speed_x_r, speed_y_r;
  logic        dead_r;
  logic [CNT_W-1:0] count_r, idx_r;

  // Attractor table
  logic [31:0] tab_x [MAX_ATTRACTORS];
  logic [31:0] tab_y [MAX_ATTRACTORS];
  logic [31:0] tab_m [MAX_ATTRACTORS];
  logic [31:0] tab_r [MAX_ATTRACTORS];
  logic [31:0] rd_x_r, rd_y_r, rd_m_r, rd_r_r;

  // Arithmetic registers
  logic [32:0] dx_r, dy_r;
  logic [32:0] ux, uy;
  logic [65:0] prod_r, sum_r, rad_r;
  logic [32:0] mul_a, mul_b;
  logic        mul_en;
  logic [31:0] p1_r, f_r;
  logic [35:0] srem_r;
  logic [32:0] root_r;
  logic [33:0] drem_r;
  logic [63:0] dvd_r;
  logic [5:0]  step_r;
  logic signed [ACC_W-1:0] acc_x_r, acc_y_r;

  // Output register
  logic [31:0] o_px_r, o_py_r, o_vx_r, o_vy_r;
  logic        o_dead_r;

  // Step logic
  logic [35:0] rsh;
  logic [34:0] trial;
  logic        rbit;
  logic [33:0] dsh;
  logic        dbit;
  logic [32:0] radsum;
  logic signed [ACC_W-1:0] comp;
  logic        load_ok;

  assign ux = dx_r[32] ? (33'd0 - dx_r) : dx_r;
  assign uy = dy_r[32] ? (33'd0 - dy_r) : dy_r;

  assign rsh   = {srem_r[33:0], rad_r[65:64]};
  assign trial = {root_r[32:0], 2'b01};
  assign rbit  = (rsh >= {1'b0, trial});

  assign dsh  = {drem_r[32:0], dvd_r[63]};
  assign dbit = (dsh >= {1'b0, root_r});

  assign radsum = {1'b0, body_radius} + {1'b0, rd_r_r};
  assign comp   = $signed({{(ACC_W-33){1'b0}}, dvd_r[32:0]});
  assign load_ok = (count_r < CNT_W'(MAX_ATTRACTORS));

  // Status toward the controller
  assign stat.kind    = kind_r;
  assign stat.dead    = dead_r;
  assign stat.idx_end = (idx_r == count_r);
  assign stat.last    = (step_r == 6'd0);
  assign stat.hit     = (root_r < radsum);
  assign stat.zero    = (root_r == 33'd0);

  // Select multiplier operands
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd)
      CMD_MUL_GM: begin
        mul_a = {1'b0, gravity_constant};
        mul_b = {1'b0, body_mass};
      end
      CMD_SQ_X: begin
        mul_a = ux;
        mul_b = ux;
      end
      CMD_SQ_Y: begin
        mul_a = uy;
        mul_b = uy;
      end
      CMD_MUL_M: begin
        mul_a = {1'b0, p1_r};
        mul_b = {1'b0, rd_m_r};
      end
      CMD_MUL_FX: begin
        mul_a = {1'b0, f_r};
        mul_b = ux;
      end
      CMD_MUL_FY: begin
        mul_a = {1'b0, f_r};
        mul_b = uy;
      end
      default: mul_en = 1'b0;
    endcase
  end

  // Table write and registered read
  always_ff @(posedge clk) begin
    if (cmd == CMD_LOAD && load_ok) begin
      tab_x[count_r[IDX_W-1:0]] <= cx_r;
      tab_y[count_r[IDX_W-1:0]] <= cy_r;
      tab_m[count_r[IDX_W-1:0]] <= cm_r;
      tab_r[count_r[IDX_W-1:0]] <= cr_r;
    end
    if (cmd == CMD_READ) begin
      rd_x_r <= tab_x[idx_r[IDX_W-1:0]];
      rd_y_r <= tab_y[idx_r[IDX_W-1:0]];
      rd_m_r <= tab_m[idx_r[IDX_W-1:0]];
      rd_r_r <= tab_r[idx_r[IDX_W-1:0]];
    end
  end

  // Control-relevant state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_x_r  <= '0;
      body_y_r  <= '0;
      speed_x_r <= '0;
      speed_y_r <= '0;
      dead_r    <= 1'b0;
      count_r   <= '0;
      idx_r     <= '0;
      kind_r    <= KIND_PLACE;
      step_r    <= '0;
    end else begin
      unique case (cmd)
        CMD_LATCH: kind_r <= in_tuser;
        CMD_PLACE: begin
          body_x_r  <= cx_r;
          body_y_r  <= cy_r;
          speed_x_r <= '0;
          speed_y_r <= '0;
          dead_r    <= 1'b0;
        end
        CMD_LOAD: if (load_ok) count_r <= count_r + 1'b1;
        CMD_TAKE_P1: idx_r <= '0;
        CMD_SUM: step_r <= 6'd32;
        CMD_DIV_Q, CMD_DIV_F, CMD_DIV_C: step_r <= 6'd63;
        CMD_ROOT, CMD_DIV: step_r <= step_r - 1'b1;
        CMD_KILL: dead_r <= 1'b1;
        CMD_SKIP, CMD_ACC_Y: idx_r <= idx_r + 1'b1;
        CMD_UPDATE: begin
          body_x_r  <= sat_s32(64'($signed(body_x_r)) + 64'($signed(speed_x_r)));
          body_y_r  <= sat_s32(64'($signed(body_y_r)) + 64'($signed(speed_y_r)));
          speed_x_r <= sat_s32(64'($signed(speed_x_r)) + 64'(acc_x_r));
          speed_y_r <= sat_s32(64'($signed(speed_y_r)) + 64'(acc_y_r));
        end
        default: ;
      endcase
    end
  end

  // Arithmetic payload
  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= mul_a * mul_b;
    case (cmd)
      CMD_LATCH: begin
        cx_r <= in_tdata[31:0];
        cy_r <= in_tdata[63:32];
        cm_r <= in_tdata[95:64];
        cr_r <= in_tdata[127:96];
        tx_r <= in_tdata[159:128];
        ty_r <= in_tdata[191:160];
      end
      CMD_TAKE_P1: begin
        p1_r    <= sat_q16(prod_r);
        acc_x_r <= ACC_W'($signed(tx_r));
        acc_y_r <= ACC_W'($signed(ty_r));
      end
      CMD_DELTA: begin
        dx_r <= {rd_x_r[31], rd_x_r} - {body_x_r[31], body_x_r};
        dy_r <= {rd_y_r[31], rd_y_r} - {body_y_r[31], body_y_r};
      end
      CMD_SQ_Y: sum_r <= prod_r;
      CMD_SUM: begin
        rad_r  <= sum_r + prod_r;
        srem_r <= '0;
        root_r <= '0;
      end
      CMD_ROOT: begin
        rad_r  <= {rad_r[63:0], 2'b00};
        srem_r <= rbit ? (rsh - {1'b0, trial}) : rsh;
        root_r <= {root_r[31:0], rbit};
      end
      CMD_DIV_Q: begin
        dvd_r  <= {16'd0, sat_q16(prod_r), 16'd0};
        drem_r <= '0;
      end
      CMD_DIV_F: begin
        dvd_r  <= {dvd_r[47:0], 16'd0};
        drem_r <= '0;
      end
      CMD_DIV_C: begin
        dvd_r  <= prod_r[63:0];
        drem_r <= '0;
      end
      CMD_DIV: begin
        drem_r <= dbit ? (dsh - {1'b0, root_r}) : dsh;
        dvd_r  <= {dvd_r[62:0], dbit};
      end
      CMD_TAKE_F: f_r <= (|dvd_r[63:32]) ? 32'hFFFF_FFFF : dvd_r[31:0];
      CMD_ACC_X: acc_x_r <= dx_r[32] ? (acc_x_r - comp) : (acc_x_r + comp);
      CMD_ACC_Y: acc_y_r <= dy_r[32] ? (acc_y_r - comp) : (acc_y_r + comp);
      CMD_PUBLISH: begin
        o_px_r   <= body_x_r;
        o_py_r   <= body_y_r;
        o_vx_r   <= speed_x_r;
        o_vy_r   <= speed_y_r;
        o_dead_r <= dead_r;
      end
      default: ;
    endcase
  end

  assign out_tdata = {o_vy_r, o_vx_r, o_py_r, o_px_r};
  assign out_tuser = o_dead_r;

endmodule
